// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rbf scorer rtl
// depends on nothing; included by rbf_svdd_outlier_scorer, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/rbf_pkg.sv -----
// shared constants, payload types and control structs for the rbf scorer
// depends on nothing; imported by every module of the block
package rbf_pkg;

    localparam int MAX_DIMS        = 64;
    localparam int EXP_TABLE_DEPTH = 1024;
    localparam int COUNT_WIDTH     = 32;

    localparam int VALUE_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int CADDR_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int POS_W    = $clog2(MAX_DIMS + 1);
    localparam int SQ_W     = 33;
    localparam int SUM_W    = 40;
    localparam int CFG_W    = 16;
    localparam int X_W      = SUM_W + CFG_W;
    localparam int XLIM_BIT = 48;
    localparam int KD_AW    = $clog2(EXP_TABLE_DEPTH);
    localparam int KD_W     = 16;
    localparam int OUT_CNT_W = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [KD_W-1:0] KD_MAX = 16'd32768;

    // operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_FEATURE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_INV_TWO_SIGMA_SQ = 1'b0;
    localparam logic REG_RADIUS_SQUARED   = 1'b1;

    localparam logic [CFG_W-1:0] INV_TWO_SIGMA_SQ_RESET = 16'd8407;
    localparam logic [CFG_W-1:0] RADIUS_SQUARED_RESET   = 16'd7377;

    typedef struct packed {
        logic [1:0]                operation;
        logic [INDEX_W-1:0]        center_index;
        logic signed [VALUE_W-1:0] value;
        logic                      label;
        logic                      last_feature;
    } item_t;

    typedef struct packed {
        logic                 outside;
        logic [KD_W-1:0]      kernel_distance;
        logic [OUT_CNT_W-1:0] correct_count;
        logic [OUT_CNT_W-1:0] outside_typical_count;
        logic [OUT_CNT_W-1:0] inside_atypical_count;
        logic [OUT_CNT_W-1:0] typical_count;
        logic [OUT_CNT_W-1:0] sample_count;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] inv_two_sigma_sq;
        logic [CFG_W-1:0] radius_squared;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic update;
        logic outside;
        logic typical;
        logic below;
    } cnt_ctrl_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] correct;
        logic [COUNT_WIDTH-1:0] outside_typical;
        logic [COUNT_WIDTH-1:0] inside_atypical;
        logic [COUNT_WIDTH-1:0] typical;
        logic [COUNT_WIDTH-1:0] sample;
    } cnt_vals_t;

endpackage

// ----- hw/rtl/rbf_regs.sv -----
// apb-style configuration registers of the rbf scorer
// depends on rbf_pkg
module rbf_regs
    import rbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_INV_TWO_SIGMA_SQ: cfg_next.inv_two_sigma_sq = pwdata[CFG_W-1:0];
                REG_RADIUS_SQUARED:   cfg_next.radius_squared   = pwdata[CFG_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_two_sigma_sq <= INV_TWO_SIGMA_SQ_RESET;
            cfg_reg.radius_squared   <= RADIUS_SQUARED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_INV_TWO_SIGMA_SQ: prdata = PDATA_W'(cfg_reg.inv_two_sigma_sq);
            REG_RADIUS_SQUARED:   prdata = PDATA_W'(cfg_reg.radius_squared);
            default:              prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/rbf_center_mem.sv -----
// center vector memory, one write port and one registered read port
// depends on rbf_pkg
module rbf_center_mem
    import rbf_pkg::*;
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [CADDR_W-1:0]        wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [CADDR_W-1:0]        rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [MAX_DIMS];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rbf_kd_rom.sv -----
// kernel distance rom: 2 - 2*exp(-x) in q2.14, built at elaboration
// depends on rbf_pkg; registered read
module rbf_kd_rom
    import rbf_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [KD_AW-1:0] rd_addr,
    output logic [KD_W-1:0]  rd_data
);

    localparam longint ONE_Q30 = longint'(1) <<< 30;

    // shift-subtract quotient, only evaluated while the table is built
    function automatic longint unsigned udiv_small(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        begin
            quo = '0;
            rem = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[62:0], num[b]};
                if (rem >= den)
                begin
                    rem    = rem - den;
                    quo[b] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // taylor series of exp(-u) in q.30 with u = k/depth, raised to the 16th power by squaring;
    // intermediate products wrap at 64 bits
    function automatic logic [KD_W-1:0] kd_entry(input int unsigned k);
        longint          u;
        longint          term;
        longint          acc;
        longint          e;
        longint unsigned num;
        begin
            u    = longint'((longint'(k) <<< 30) >>> KD_AW);
            term = ONE_Q30;
            acc  = ONE_Q30;
            for (int i = 1; i <= 24; i++)
            begin
                term = (term * u) >>> 30;
                term = signed'(udiv_small(unsigned'(term), 64'(i)));
                if ((i & 1) == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc < 0)
                acc = 0;
            if (acc > ONE_Q30)
                acc = ONE_Q30;
            e = acc;
            for (int j = 0; j < 4; j++)
            begin
                e = (e * e) >>> 30;
            end
            if (e > ONE_Q30)
                e = ONE_Q30;
            num = longint'(ONE_Q30 - e) * 64'd32768 + (64'd1 << 29);
            return KD_W'(num >> 30);
        end
    endfunction

    logic [KD_W-1:0] rom_tab [EXP_TABLE_DEPTH];
    logic [KD_W-1:0] rd_data_reg;

    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_entry
        localparam logic [KD_W-1:0] ENTRY = kd_entry(g);
        assign rom_tab[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_tab[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rbf_counters.sv -----
// saturating score counters with a synchronous clear
// depends on rbf_pkg
module rbf_counters
    import rbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cnt_ctrl_t ctrl,
    output cnt_vals_t counts
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    cnt_vals_t cnt_reg;
    cnt_vals_t cnt_next;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c,
                                                       input logic en);
        begin
            if (en && c != COUNT_MAX)
                return c + COUNT_WIDTH'(1);
            return c;
        end
    endfunction

    always_comb
    begin
        cnt_next = cnt_reg;
        priority if (ctrl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctrl.update)
        begin
            cnt_next.correct = sat_inc(cnt_reg.correct, ctrl.outside ^ ctrl.typical);
            cnt_next.outside_typical = sat_inc(cnt_reg.outside_typical,
                                               ctrl.outside && ctrl.typical);
            cnt_next.inside_atypical = sat_inc(cnt_reg.inside_atypical,
                                               ctrl.below && !ctrl.typical);
            cnt_next.typical = sat_inc(cnt_reg.typical, ctrl.typical);
            cnt_next.sample  = sat_inc(cnt_reg.sample, 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign counts = cnt_reg;

endmodule

// ----- hw/rtl/rbf_svdd_outlier_scorer.sv -----
// top level of the svdd outlier scorer with rbf kernel distance
// depends on rbf_pkg, rbf_regs, rbf_center_mem, rbf_kd_rom, rbf_counters, assert_macros.svh
//
// One item is taken at a time. A center load, a counter clear or operation
// three is taken without leaving S_IDLE. A feature goes through the center
// memory read, one 17x17 square and a saturating 40-bit accumulate. A last
// feature adds the 40x16 sum-by-scale multiply, the kernel rom read, the
// compare and counter update, and the move into the result register; the move
// waits while an earlier result is still unclaimed downstream. The result
// register parts the two sides, so the next item is taken while a result
// waits. The center memory has no reset; elements must be loaded before use.
`include "assert_macros.svh"

module rbf_svdd_outlier_scorer
    import rbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // ready for a transfer
    localparam logic [2:0] S_SQ   = 3'd1;  // center data back, square the difference
    localparam logic [2:0] S_ACC  = 3'd2;  // accumulate into the distance sum
    localparam logic [2:0] S_MUL  = 3'd3;  // scale the sum by 1/(2 sigma^2)
    localparam logic [2:0] S_ROM  = 3'd4;  // kernel rom lookup
    localparam logic [2:0] S_CMP  = 3'd5;  // compare with radius, update counters
    localparam logic [2:0] S_OUT  = 3'd6;  // hand over to the result register

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    cfg_t cfg;

    // sample state
    logic [SUM_W-1:0] sum_reg;
    logic [POS_W-1:0] pos_reg;

    // per-feature working registers
    logic signed [VALUE_W-1:0] value_reg;
    logic                      label_reg;
    logic                      last_reg;
    logic                      in_range_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [X_W-1:0]            x_reg;
    logic                      big_reg;
    logic [KD_W-1:0]           kd_reg;
    logic                      outside_reg;

    // result register
    logic    result_valid_reg;
    result_t result_reg;

    logic accept;
    logic out_load;

    logic                      mem_wr_en;
    logic                      mem_rd_en;
    logic signed [VALUE_W-1:0] center_rd;
    logic signed [VALUE_W:0]   diff;
    logic signed [2*VALUE_W+1:0] prod;
    logic [SUM_W:0]            sum_add;
    logic [KD_W-1:0]           kd_rd;
    logic [KD_W-1:0]           kd_val;

    cnt_ctrl_t cnt_ctrl;
    cnt_vals_t counts;

    function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] w;
        begin
            w = 64'(c);
            return w[OUT_CNT_W-1:0];
        end
    endfunction

    rbf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // loads beyond the memory depth are dropped
    assign mem_wr_en = accept && (item.operation == OP_LOAD) &&
                       ({1'b0, item.center_index} < (INDEX_W + 1)'(MAX_DIMS));
    // read the center element at the current feature position as the feature comes in
    assign mem_rd_en = accept && (item.operation == OP_FEATURE);

    rbf_center_mem u_center_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (CADDR_W'(item.center_index)),
        .wr_data (item.value),
        .rd_en   (mem_rd_en),
        .rd_addr (pos_reg[CADDR_W-1:0]),
        .rd_data (center_rd)
    );

    // difference and square, one multiplier
    assign diff = $signed({value_reg[VALUE_W-1], value_reg}) -
                  $signed({center_rd[VALUE_W-1], center_rd});
    assign prod = diff * diff;

    // saturating accumulate
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    // kernel rom indexed by the top bits of the scaled distance below 16.0
    rbf_kd_rom u_kd_rom (
        .clk     (clk),
        .rd_en   (state_reg == S_ROM),
        .rd_addr (x_reg[XLIM_BIT-1 -: KD_AW]),
        .rd_data (kd_rd)
    );

    assign kd_val = big_reg ? KD_MAX : kd_rd;

    always_comb
    begin
        cnt_ctrl.clear   = accept && (item.operation == OP_CLEAR);
        cnt_ctrl.update  = (state_reg == S_CMP);
        cnt_ctrl.outside = (kd_val > cfg.radius_squared);
        cnt_ctrl.typical = label_reg;
        cnt_ctrl.below   = (kd_val < cfg.radius_squared);
    end

    rbf_counters u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cnt_ctrl),
        .counts (counts)
    );

    assign out_load = (state_reg == S_OUT) && (!result_valid_reg || result_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.operation == OP_FEATURE)
                    state_next = S_SQ;
            end
            S_SQ:  state_next = S_ACC;
            S_ACC: state_next = last_reg ? S_MUL : S_IDLE;
            S_MUL: state_next = S_ROM;
            S_ROM: state_next = S_CMP;
            S_CMP: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sum_reg          <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACC)
            begin
                sum_reg <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                if (in_range_reg)
                    pos_reg <= pos_reg + POS_W'(1);
            end
            else if (state_reg == S_CMP)
            begin
                // sample done, start the next one from zero
                sum_reg <= '0;
                pos_reg <= '0;
            end
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg    <= item.value;
            label_reg    <= item.label;
            last_reg     <= item.last_feature;
            // features past the last center element add nothing
            in_range_reg <= (pos_reg < POS_W'(MAX_DIMS));
        end
        if (state_reg == S_SQ)
            sq_reg <= in_range_reg ? prod[SQ_W-1:0] : '0;
        if (state_reg == S_MUL)
            x_reg <= X_W'(sum_reg) * X_W'(cfg.inv_two_sigma_sq);
        if (state_reg == S_ROM)
            big_reg <= |x_reg[X_W-1:XLIM_BIT];
        if (state_reg == S_CMP)
        begin
            kd_reg      <= kd_val;
            outside_reg <= cnt_ctrl.outside;
        end
        if (out_load)
        begin
            result_reg.outside               <= outside_reg;
            result_reg.kernel_distance       <= kd_reg;
            result_reg.correct_count         <= cnt_out(counts.correct);
            result_reg.outside_typical_count <= cnt_out(counts.outside_typical);
            result_reg.inside_atypical_count <= cnt_out(counts.inside_atypical);
            result_reg.typical_count         <= cnt_out(counts.typical);
            result_reg.sample_count          <= cnt_out(counts.sample);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a feature transfer always starts the square step
    `ASSERT_NEXT(a_feature_starts, clk, rst_n, accept && item.operation == OP_FEATURE, state_reg == S_SQ)
    // a finished sample leaves the sum and position cleared
    `ASSERT_NEXT(a_sample_cleared, clk, rst_n, state_reg == S_CMP, sum_reg == '0 && pos_reg == '0)
    // a pending result is never overwritten by the next one
    `ASSERT_NEXT(a_out_holds, clk, rst_n, state_reg == S_OUT && result_valid && !result_ready, state_reg == S_OUT)

endmodule

// ----- tb/tb_rbf_svdd_outlier_scorer.sv -----
// self-checking testbench for the svdd outlier scorer with rbf kernel distance
// depends on rbf_pkg and rbf_svdd_outlier_scorer; predicts every score and checks each result transfer
// directed samples first, then mixed random traffic under several register settings and idle patterns
module tb_rbf_svdd_outlier_scorer;
    import rbf_pkg::*;

    localparam int          RESET_CYCLES  = 9;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          PHASE_COUNT   = 8;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          FULL_SCALE    = -1;
    localparam longint      LIMIT_TIME    = 64'd5_000_000;
    localparam longint      ONE_Q30       = 64'sd1 << 30;
    localparam logic [63:0] SUM_LIMIT     = (64'd1 << SUM_W) - 1;
    localparam logic [63:0] X_LIMIT       = 64'd1 << XLIM_BIT;
    // operation three carries no meaning and must be dropped
    localparam logic [1:0]  OP_IGNORED    = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_t              item_data;
    logic               result_valid;
    logic               result_ready;
    result_t            result_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // idle and stall percentages of the current phase
    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;

    // scorer shadow state
    logic [KD_W-1:0]           kd_lut [EXP_TABLE_DEPTH];
    logic signed [VALUE_W-1:0] center_copy [MAX_DIMS];
    logic [SUM_W-1:0]          dist_acc;
    int                        feat_pos;
    logic [CFG_W-1:0]          inv_cfg;
    logic [CFG_W-1:0]          rad_cfg;
    logic [COUNT_WIDTH-1:0]    cnt_correct;
    logic [COUNT_WIDTH-1:0]    cnt_out_typ;
    logic [COUNT_WIDTH-1:0]    cnt_in_atyp;
    logic [COUNT_WIDTH-1:0]    cnt_typical;
    logic [COUNT_WIDTH-1:0]    cnt_samples;

    // scores still owed by the block, oldest first
    result_t pending_scores [$];
    result_t oldest_score;

    rbf_svdd_outlier_scorer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // kernel distance table: 2 - 2*exp(-x) at x = 16*k/depth, exp(-x) as (exp(-x/16))^16
    task automatic build_kd_lut;
        longint u;
        longint term;
        longint acc;
        longint e;
        int     k;
        int     i;
        begin
            for (k = 0; k < EXP_TABLE_DEPTH; k++)
            begin
                u    = (longint'(k) << 30) / EXP_TABLE_DEPTH;
                term = ONE_Q30;
                acc  = ONE_Q30;
                // taylor series of exp(-u) in q.30
                for (i = 1; i <= 24; i++)
                begin
                    term = ((term * u) >>> 30) / i;
                    if (i % 2 == 1)
                        acc = acc - term;
                    else
                        acc = acc + term;
                end
                if (acc < 0)
                    acc = 0;
                if (acc > ONE_Q30)
                    acc = ONE_Q30;
                e = acc;
                // four squarings take exp(-x/16) to exp(-x)
                for (i = 0; i < 4; i++)
                    e = (e * e) >>> 30;
                if (e > ONE_Q30)
                    e = ONE_Q30;
                kd_lut[k] = KD_W'(((ONE_Q30 - e) * 32768 + (ONE_Q30 >>> 1)) >>> 30);
            end
        end
    endtask

    // saturating counter step
    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        return (c != '1) ? c + 1'b1 : c;
    endfunction

    function automatic item_t make_item(input logic [1:0] op, input logic [INDEX_W-1:0] idx,
                                        input logic signed [VALUE_W-1:0] v, input logic lbl,
                                        input logic last);
        item_t it;
        it.operation    = op;
        it.center_index = idx;
        it.value        = v;
        it.label        = lbl;
        it.last_feature = last;
        return it;
    endfunction

    // applies one accepted item to the shadow state; a last feature queues its score
    task automatic score_item(input item_t it);
        longint           d;
        logic [63:0]      sq;
        logic [63:0]      x;
        logic [KD_W-1:0]  kd;
        logic             outside_f;
        result_t          r;
        begin
            case (it.operation)
                OP_LOAD:
                begin
                    if (it.center_index < MAX_DIMS)
                        center_copy[it.center_index] = it.value;
                end
                OP_CLEAR:
                begin
                    // counters only, a sample in flight keeps its partial sum
                    cnt_correct = '0;
                    cnt_out_typ = '0;
                    cnt_in_atyp = '0;
                    cnt_typical = '0;
                    cnt_samples = '0;
                end
                OP_FEATURE:
                begin
                    // features past the last center element add nothing
                    if (feat_pos < MAX_DIMS)
                    begin
                        d        = longint'(it.value) - longint'(center_copy[feat_pos]);
                        sq       = 64'(d * d);
                        dist_acc = SUM_W'((sq > SUM_LIMIT - 64'(dist_acc)) ? SUM_LIMIT
                                                                         : 64'(dist_acc) + sq);
                        feat_pos++;
                    end
                    if (it.last_feature)
                    begin
                        // q4.28 sum times q0.16 scale gives x in q.44
                        x = 64'(dist_acc) * 64'(inv_cfg);
                        if (x >= X_LIMIT)
                            kd = KD_MAX;
                        else
                            kd = kd_lut[int'((x << KD_AW) >> XLIM_BIT)];
                        outside_f = kd > rad_cfg;
                        if (outside_f != it.label)
                            cnt_correct = bump(cnt_correct);
                        if (outside_f && it.label)
                            cnt_out_typ = bump(cnt_out_typ);
                        // a distance equal to the radius is not outside, yet it is not counted as inside here
                        if (kd < rad_cfg && !it.label)
                            cnt_in_atyp = bump(cnt_in_atyp);
                        if (it.label)
                            cnt_typical = bump(cnt_typical);
                        cnt_samples = bump(cnt_samples);
                        r.outside               = outside_f;
                        r.kernel_distance       = kd;
                        r.correct_count         = OUT_CNT_W'(cnt_correct);
                        r.outside_typical_count = OUT_CNT_W'(cnt_out_typ);
                        r.inside_atypical_count = OUT_CNT_W'(cnt_in_atyp);
                        r.typical_count         = OUT_CNT_W'(cnt_typical);
                        r.sample_count          = OUT_CNT_W'(cnt_samples);
                        pending_scores.push_back(r);
                        dist_acc = '0;
                        feat_pos = 0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        begin
            if (act_v !== exp_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                mismatch_count++;
            end
        end
    endtask

    // result side: compare every transfer with the oldest owed score
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("result transfer with no score owed: kernel_distance %0d",
                       result_data.kernel_distance);
                mismatch_count++;
            end
            else
            begin
                oldest_score = pending_scores.pop_front();
                check_field("outside", 32'(oldest_score.outside), 32'(result_data.outside));
                check_field("kernel_distance", 32'(oldest_score.kernel_distance),
                            32'(result_data.kernel_distance));
                check_field("correct_count", oldest_score.correct_count,
                            result_data.correct_count);
                check_field("outside_typical_count", oldest_score.outside_typical_count,
                            result_data.outside_typical_count);
                check_field("inside_atypical_count", oldest_score.inside_atypical_count,
                            result_data.inside_atypical_count);
                check_field("typical_count", oldest_score.typical_count,
                            result_data.typical_count);
                check_field("sample_count", oldest_score.sample_count,
                            result_data.sample_count);
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // one item transfer; the sender may idle first, valid then holds until accepted
    task automatic send_item(input item_t it);
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid = 1'b0;
                @(negedge clk);
            end
            item_valid = 1'b1;
            item_data  = it;
            @(posedge clk);
            while (!item_ready)
                @(posedge clk);
            score_item(it);
        end
    endtask

    task automatic send_feature(input logic signed [VALUE_W-1:0] v, input logic lbl,
                                input logic last);
        begin
            send_item(make_item(OP_FEATURE, INDEX_W'($urandom), v, lbl, last));
        end
    endtask

    task automatic send_clear;
        begin
            send_item(make_item(OP_CLEAR, INDEX_W'($urandom), VALUE_W'($urandom),
                                1'($urandom), 1'($urandom)));
        end
    endtask

    task automatic send_ignored;
        begin
            send_item(make_item(OP_IGNORED, INDEX_W'($urandom), VALUE_W'($urandom),
                                1'($urandom), 1'($urandom)));
        end
    endtask

    // drop valid, wait for every owed score, then let any featureless work finish
    task automatic wait_idle;
        begin
            @(negedge clk);
            item_valid = 1'b0;
            while (pending_scores.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(input logic reg_sel, input logic [CFG_W-1:0] v);
        begin
            @(negedge clk);
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b1;
            paddr   = {reg_sel, 2'b00};
            pwdata  = PDATA_W'(v);
            @(negedge clk);
            penable = 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
            if (reg_sel == REG_INV_TWO_SIGMA_SQ)
                inv_cfg = v;
            else
                rad_cfg = v;
        end
    endtask

    // value near the center element the next feature is scored against, or any value at full scale
    function automatic logic signed [VALUE_W-1:0] near_center(input int scale);
        int base;
        base = (feat_pos < MAX_DIMS) ? int'(center_copy[feat_pos]) : 0;
        if (scale == FULL_SCALE)
            return VALUE_W'($urandom);
        return VALUE_W'(base + int'($urandom_range(2 * scale)) - scale);
    endfunction

    // every center element is written before any feature reads it
    task automatic test_center_load;
        int i;
        begin
            for (i = 0; i < MAX_DIMS; i++)
            begin
                // low elements alternate the two extremes for the far-distance samples
                if (i < 16)
                    send_item(make_item(OP_LOAD, INDEX_W'(i),
                                        (i % 2 == 0) ? 16'sh8000 : 16'sh7FFF, 1'b0, 1'b0));
                else
                    send_item(make_item(OP_LOAD, INDEX_W'(i), VALUE_W'($urandom),
                                        1'($urandom), 1'($urandom)));
            end
        end
    endtask

    task automatic test_directed_samples;
        int j;
        begin
            // zero distance, typical then atypical
            send_feature(center_copy[0], 1'b1, 1'b1);
            send_feature(center_copy[0], 1'b0, 1'b1);
            // full-scale differences over ten features push x past the table
            for (j = 0; j < 10; j++)
                send_feature(~center_copy[j], 1'b0, j == 9);
            // counter clear and a dropped operation in the middle of a sample
            send_feature(center_copy[0] + 16'sd4096, 1'b1, 1'b0);
            send_clear;
            send_item(make_item(OP_IGNORED, '1, '1, 1'b1, 1'b1));
            send_feature(center_copy[1], 1'b1, 1'b1);
            // single features at moderate distance
            send_feature(center_copy[0] + 16'sd8192, 1'b0, 1'b1);
            send_feature(center_copy[0] - 16'sd2048, 1'b1, 1'b1);
            // rewrite an element and score against the new value
            send_item(make_item(OP_LOAD, '0, 16'sd0, 1'b0, 1'b0));
            send_feature(16'sd0, 1'b1, 1'b1);
        end
    endtask

    // mostly whole samples with random content, plus loads, clears and noise
    task automatic run_mixed_traffic(input int target);
        int   sent;
        int   pick;
        int   len;
        int   scale;
        int   j;
        logic lbl;
        begin
            sent = 0;
            while (sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                begin
                    send_item(make_item(OP_LOAD, INDEX_W'($urandom), VALUE_W'($urandom),
                                        1'($urandom), 1'($urandom)));
                    sent++;
                end
                else if (pick < 8)
                begin
                    send_clear;
                    sent++;
                end
                else if (pick < 10)
                    send_ignored;
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 10)
                        len = 1;
                    else if (pick < 85)
                        len = $urandom_range(12, 2);
                    else if (pick < 95)
                        len = $urandom_range(MAX_DIMS, 13);
                    else
                        len = $urandom_range(MAX_DIMS + 8, MAX_DIMS + 1);
                    case ($urandom_range(5))
                        0:       scale = 0;
                        1:       scale = 64;
                        2:       scale = 1024;
                        3:       scale = 4096;
                        4:       scale = 16384;
                        default: scale = FULL_SCALE;
                    endcase
                    lbl = 1'($urandom);
                    for (j = 0; j < len; j++)
                    begin
                        // occasional noise and clears inside the sample
                        if ($urandom_range(99) < 3)
                            send_ignored;
                        if ($urandom_range(199) == 0)
                            send_clear;
                        send_feature(near_center(scale), (j == len - 1) ? lbl : 1'($urandom),
                                     j == len - 1);
                        sent++;
                    end
                end
            end
        end
    endtask

    // each phase: idle block, new register values, idle and stall settings, then random traffic
    task automatic test_register_sweep;
        int               p;
        logic [CFG_W-1:0] inv_v;
        logic [CFG_W-1:0] rad_v;
        begin
            for (p = 0; p < PHASE_COUNT; p++)
            begin
                wait_idle;
                case (p)
                    0:
                    begin
                        inv_v = INV_TWO_SIGMA_SQ_RESET;
                        rad_v = RADIUS_SQUARED_RESET;
                    end
                    1:
                    begin
                        inv_v = '1;
                        rad_v = '0;
                    end
                    2:
                    begin
                        inv_v = '0;
                        rad_v = '1;
                    end
                    3:
                    begin
                        inv_v = '1;
                        rad_v = KD_MAX;
                    end
                    default:
                    begin
                        inv_v = CFG_W'($urandom);
                        rad_v = CFG_W'($urandom_range(32768));
                    end
                endcase
                write_register(REG_INV_TWO_SIGMA_SQ, inv_v);
                write_register(REG_RADIUS_SQUARED, rad_v);
                case (p % 4)
                    0:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    1:
                    begin
                        send_idle_pct  = 50;
                        recv_stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 50;
                    end
                    default:
                    begin
                        send_idle_pct  = 36;
                        recv_stall_pct = 36;
                    end
                endcase
                run_mixed_traffic(PHASE_ITEMS);
            end
        end
    endtask

    // watchdog
    initial
    begin
        #(LIMIT_TIME);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item_data      = '0;
        result_ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        // shadow state after reset
        build_kd_lut;
        foreach (center_copy[i])
            center_copy[i] = '0;
        dist_acc    = '0;
        feat_pos    = 0;
        inv_cfg     = INV_TWO_SIGMA_SQ_RESET;
        rad_cfg     = RADIUS_SQUARED_RESET;
        cnt_correct = '0;
        cnt_out_typ = '0;
        cnt_in_atyp = '0;
        cnt_typical = '0;
        cnt_samples = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_center_load;
        test_directed_samples;
        test_register_sweep;

        wait_idle;
        if (mismatch_count == 0 && pending_scores.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rbf_pkg.sv
hw/rtl/rbf_regs.sv
hw/rtl/rbf_center_mem.sv
hw/rtl/rbf_kd_rom.sv
hw/rtl/rbf_counters.sv
hw/rtl/rbf_svdd_outlier_scorer.sv
tb/tb_rbf_svdd_outlier_scorer.sv
